>>> design/i2cm_pkg.sv
package i2cm_pkg;

    // command codes carried in the opcode field
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_DELAY = 1'b0;
    localparam logic CFG_ACK_TIMEOUT     = 1'b1;

    localparam int unsigned CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] TICKS_PER_DELAY_RESET = 16'd1;
    localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RESET     = 16'd250;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // one tick request
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_level;
    } item_t;

    // one tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       nack;
    } res_t;

    // configuration values seen by the sequencer
    typedef struct packed {
        logic [CFG_WIDTH-1:0] ticks_per_delay;
        logic [CFG_WIDTH-1:0] ack_timeout;
    } cfg_t;

endpackage

>>> design/i2cm_seq.sv
module i2cm_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  i2cm_pkg::item_t item,
    input  i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::res_t  res
);

    // one-hot command state
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_STOP  = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_READ  = 6'b010000,
        ST_WAIT  = 6'b100000
    } st_t;

    st_t         st_reg, st_next;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [16:0] tick_reg, tick_next;
    logic [15:0] retry_reg, retry_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        nack_reg, nack_next;
    logic [7:0]  read_byte_reg, read_byte_next;

    logic        go;
    logic        done;
    logic [16:0] delay_eff;
    logic [16:0] hold1;
    logic [16:0] hold2;
    st_t         op_st;

    // hold lengths for one and two delay units
    assign delay_eff = (cfg.ticks_per_delay == '0) ? 17'd1 : {1'b0, cfg.ticks_per_delay};
    assign hold1     = delay_eff - 17'd1;
    assign hold2     = {delay_eff[15:0], 1'b0} - 17'd1;

    // opcode decode
    always_comb
    begin
        unique case (item.opcode)
            i2cm_pkg::OP_START: op_st = ST_START;
            i2cm_pkg::OP_STOP:  op_st = ST_STOP;
            i2cm_pkg::OP_WRITE: op_st = ST_WRITE;
            i2cm_pkg::OP_READ:  op_st = ST_READ;
            i2cm_pkg::OP_WAIT:  op_st = ST_WAIT;
            default:            op_st = ST_IDLE;
        endcase
    end

    // sequencer next state: a step may chain into one more step in the same tick
    always_comb
    begin
        st_next         = st_reg;
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        tick_next       = tick_reg;
        retry_next      = retry_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        nack_next       = nack_reg;
        read_byte_next  = read_byte_reg;
        done            = 1'b0;
        go              = 1'b0;

        // command launch, hold countdown, or the next step once the hold ends
        if (st_reg == ST_IDLE)
        begin
            if (op_st != ST_IDLE)
            begin
                st_next      = op_st;
                phase_next   = 3'd0;
                bit_cnt_next = 4'd0;
                tick_next    = 17'd0;
                if (op_st == ST_WRITE)
                begin
                    shift_next = item.write_data;
                end
                if (op_st == ST_READ)
                begin
                    shift_next      = 8'd0;
                    ack_choice_next = item.send_ack;
                end
                go = 1'b1;
            end
        end
        else if (tick_reg != 17'd0)
        begin
            tick_next = tick_reg - 17'd1;
        end
        else
        begin
            go = 1'b1;
        end

        // pin steps of the active command
        for (int it = 0; it < 2; it++)
        begin
            if (go)
            begin
                go = 1'b0;
                unique case (st_next)
                    ST_START:
                    begin
                        case (phase_next)
                            3'd0:
                            begin
                                scl_next = 1'b1; sda_next = 1'b1;
                                tick_next = hold1; phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                sda_next = 1'b0; tick_next = hold1; phase_next = 3'd2;
                            end
                            default:
                            begin
                                scl_next = 1'b0;
                                st_next = ST_IDLE; phase_next = 3'd0; done = 1'b1;
                            end
                        endcase
                    end
                    ST_STOP:
                    begin
                        case (phase_next)
                            3'd0:
                            begin
                                scl_next = 1'b0; sda_next = 1'b0;
                                tick_next = hold1; phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                scl_next = 1'b1; sda_next = 1'b1;
                                tick_next = hold1; phase_next = 3'd2;
                            end
                            default:
                            begin
                                st_next = ST_IDLE; phase_next = 3'd0; done = 1'b1;
                            end
                        endcase
                    end
                    ST_WRITE:
                    begin
                        case (phase_next)
                            3'd0:
                            begin
                                scl_next   = 1'b0;
                                sda_next   = shift_next[7];
                                shift_next = {shift_next[6:0], 1'b0};
                                tick_next  = hold1; phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                scl_next = 1'b1; tick_next = hold1; phase_next = 3'd2;
                            end
                            default:
                            begin
                                scl_next     = 1'b0;
                                bit_cnt_next = bit_cnt_next + 4'd1;
                                if (bit_cnt_next < i2cm_pkg::BITS_PER_BYTE)
                                begin
                                    phase_next = 3'd0;
                                    go = 1'b1;
                                end
                                else
                                begin
                                    st_next = ST_IDLE; phase_next = 3'd0; done = 1'b1;
                                end
                            end
                        endcase
                    end
                    ST_READ:
                    begin
                        case (phase_next)
                            3'd0:
                            begin
                                scl_next = 1'b0; sda_next = 1'b1;
                                tick_next = hold2; phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                scl_next   = 1'b1;
                                shift_next = {shift_next[6:0], item.sda_level};
                                tick_next  = hold1; phase_next = 3'd2;
                            end
                            3'd2:
                            begin
                                bit_cnt_next = bit_cnt_next + 4'd1;
                                if (bit_cnt_next < i2cm_pkg::BITS_PER_BYTE)
                                begin
                                    phase_next = 3'd0;
                                    go = 1'b1;
                                end
                                else
                                begin
                                    read_byte_next = shift_next;
                                    scl_next       = 1'b0;
                                    sda_next       = !ack_choice_next;
                                    tick_next      = hold1; phase_next = 3'd3;
                                end
                            end
                            3'd3:
                            begin
                                scl_next = 1'b1; tick_next = hold1; phase_next = 3'd4;
                            end
                            default:
                            begin
                                scl_next = 1'b0;
                                st_next = ST_IDLE; phase_next = 3'd0; done = 1'b1;
                            end
                        endcase
                    end
                    ST_WAIT:
                    begin
                        case (phase_next)
                            3'd0:
                            begin
                                sda_next = 1'b1; tick_next = hold1; phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                scl_next   = 1'b1; tick_next = hold1;
                                retry_next = cfg.ack_timeout;
                                phase_next = 3'd2;
                            end
                            default:
                            begin
                                tick_next = 17'd0;
                                if (!item.sda_level)
                                begin
                                    scl_next = 1'b0; nack_next = 1'b0;
                                    st_next = ST_IDLE; phase_next = 3'd0; done = 1'b1;
                                end
                                else if (retry_next <= 16'd1)
                                begin
                                    // timeout: flag nack and run a stop right away
                                    retry_next = 16'd0;
                                    nack_next  = 1'b1;
                                    st_next    = ST_STOP;
                                    phase_next = 3'd0;
                                    go = 1'b1;
                                end
                                else
                                begin
                                    retry_next = retry_next - 16'd1;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        st_next = ST_IDLE; phase_next = 3'd0;
                    end
                endcase
            end
        end
    end

    // state registers, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            phase_reg      <= 3'd0;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            tick_reg       <= 17'd0;
            retry_reg      <= 16'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            nack_reg       <= 1'b0;
            read_byte_reg  <= 8'd0;
        end
        else if (step)
        begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            tick_reg       <= tick_next;
            retry_reg      <= retry_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            nack_reg       <= nack_next;
            read_byte_reg  <= read_byte_next;
        end
    end

    // result of this tick
    assign res.scl_level   = scl_next;
    assign res.sda_release = sda_next;
    assign res.busy        = (st_next != ST_IDLE);
    assign res.done        = done;
    assign res.read_data   = read_byte_next;
    assign res.nack        = nack_next;

endmodule

>>> design/i2c_master_byte_engine_core.sv
// I2C master byte engine: one request per bus tick.
// Input channel (in_valid / in_stall): opcode, write_data, send_ack and the
// sampled sda_level for one tick. An opcode is taken only on a tick that
// starts idle; otherwise it is ignored.
// Output channel (out_valid / out_stall): exactly one result per request,
// carrying scl_level, sda_release (open drain, 1 = released), busy_res,
// done_res, read_data and nack.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 ticks_per_delay, 1 ack_timeout); write only while idle.
// Timing: an accepted request is registered in the input register, and its
// result is registered in the result register once the output is free.
// Throughput: one request per cycle while out_stall is low; the sequencer step
// between the input and result registers is pin-step logic that may chain steps.
// Reset: both lines released high, no command active, nack and read_data
// cleared, ticks_per_delay = 1 and ack_timeout = 250; no clearing pass.
// Stall: while out_stall holds a result, one more request is buffered in the
// input register, then in_stall rises until the result is taken.
module i2c_master_byte_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  write_data,
    input  logic        send_ack,
    input  logic        sda_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        nack,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic            pend_reg;
    i2cm_pkg::item_t item_reg;
    logic            out_valid_reg;
    i2cm_pkg::res_t  res_reg;
    i2cm_pkg::res_t  res_next;
    i2cm_pkg::cfg_t  cfg_reg;
    logic            advance;
    logic            in_take;

    // handshake
    assign advance  = pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall = pend_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_delay <= i2cm_pkg::TICKS_PER_DELAY_RESET;
            cfg_reg.ack_timeout     <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cm_pkg::CFG_TICKS_PER_DELAY: cfg_reg.ticks_per_delay <= cfg_wdata;
                i2cm_pkg::CFG_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= cfg_wdata;
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (in_take)
        begin
            pend_reg <= 1'b1;
        end
        else if (advance)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode     <= opcode;
            item_reg.write_data <= write_data;
            item_reg.send_ack   <= send_ack;
            item_reg.sda_level  <= sda_level;
        end
    end

    // bus sequencer
    i2cm_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_level   = res_reg.scl_level;
    assign sda_release = res_reg.sda_release;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign read_data   = res_reg.read_data;
    assign nack        = res_reg.nack;

`ifndef SYNTHESIS
    // a finished command never reports busy in the same result
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done and busy in one result");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // a buffered request moves to the output when the output is free
    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("buffered request not delivered");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !pend_reg) |=> !out_valid_reg)
        else $error("result repeated");
`endif

endmodule
